### rtl/core/sewl_pkg.sv
package sewl_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOTAG = 2'd3;

    // best-so-far value meaning "nothing qualified yet"
    localparam logic [1:0] NO_MATCH_WILD = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] foreign_addr;
        logic [15:0] foreign_port;
        logic [31:0] local_addr;
        logic [15:0] local_port;
        logic        allow_wildcard;
        logic [7:0]  entry_tag;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] found_tag;
        logic [1:0] wildcard_count;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] local_addr;
        logic [15:0] local_port;
        logic [31:0] foreign_addr;
        logic [15:0] foreign_port;
        logic [7:0]  tag;
    } t_entry;

    // per-cell compare result, shifted toward cell 0 during a scan
    typedef struct packed {
        logic       hit;
        logic [1:0] wild;
        logic [7:0] tag;
    } t_scan;

    typedef struct packed {
        logic insert;
        logic load;
        logic shift;
        logic remove;
    } t_cell_ctl;

endpackage

### rtl/core/sewl_cell.sv
module sewl_cell #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX   = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sewl_pkg::t_cell_ctl      i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_hit_idx,
    input  sewl_pkg::t_req           i_req,
    input  sewl_pkg::t_entry         i_newer,
    input  sewl_pkg::t_entry         i_older,
    input  sewl_pkg::t_scan          i_older_scan,
    output sewl_pkg::t_entry         o_entry,
    output sewl_pkg::t_scan          o_scan
);
    import sewl_pkg::*;

    localparam int unsigned IDXW = $clog2(DEPTH);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    t_entry r_entry;
    t_scan  r_scan;
    t_scan  cmp;

    always_comb begin
        logic       fail;
        logic [1:0] wild;
        fail = !r_entry.valid || (r_entry.local_port != i_req.local_port);
        wild = 2'd0;
        if (r_entry.local_addr != 32'd0) begin
            if (i_req.local_addr == 32'd0) begin
                wild = wild + 2'd1;
            end else if (r_entry.local_addr != i_req.local_addr) begin
                fail = 1'b1;
            end
        end else if (i_req.local_addr != 32'd0) begin
            wild = wild + 2'd1;
        end
        if (r_entry.foreign_addr != 32'd0) begin
            if (i_req.foreign_addr == 32'd0) begin
                wild = wild + 2'd1;
            end else if (r_entry.foreign_addr != i_req.foreign_addr ||
                         r_entry.foreign_port != i_req.foreign_port) begin
                fail = 1'b1;
            end
        end else if (i_req.foreign_addr != 32'd0) begin
            wild = wild + 2'd1;
        end
        if (wild != 2'd0 && !i_req.allow_wildcard) begin
            fail = 1'b1;
        end
        cmp.tag = r_entry.tag;
        if (i_req.mode == MODE_REMOVE) begin
            cmp.hit  = r_entry.valid && (r_entry.tag == i_req.entry_tag);
            cmp.wild = 2'd0;
        end else begin
            cmp.hit  = !fail;
            cmp.wild = wild;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_scan.hit    <= 1'b0;
        end else begin
            if (i_ctl.insert) begin
                r_entry <= i_newer;
            end else if (i_ctl.remove && (MY_IDX >= i_hit_idx)) begin
                r_entry <= i_older;
            end
            if (i_ctl.load) begin
                r_scan <= cmp;
            end else if (i_ctl.shift) begin
                r_scan <= i_older_scan;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_scan  = r_scan;

endmodule

### rtl/core/sewl_ctrl.sv
module sewl_ctrl #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [1:0]               i_mode,
    input  sewl_pkg::t_scan          i_head,
    input  logic                     i_full,
    output sewl_pkg::t_cell_ctl      o_ctl,
    output logic [$clog2(DEPTH)-1:0] o_hit_idx,
    output logic                     o_busy,
    output logic                     o_done,
    output sewl_pkg::t_rsp           o_rsp
);
    import sewl_pkg::*;

    localparam int unsigned IDXW = $clog2(DEPTH);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);

    typedef enum logic {
        IDLE,
        SCAN
    } t_state;

    t_state          r_state;
    logic [1:0]      r_mode;
    logic [IDXW-1:0] r_cnt;
    logic [1:0]      r_best;
    logic [7:0]      r_tag;
    logic [IDXW-1:0] r_idx;
    logic            r_done;
    t_rsp            r_rsp;

    logic            accept;
    logic            last;
    logic            better;
    logic [1:0]      cur_best;
    logic [7:0]      cur_tag;
    logic [IDXW-1:0] cur_idx;
    logic            found;
    t_cell_ctl       ctl;

    assign accept = i_start && (r_state == IDLE);
    assign last   = (r_state == SCAN) && (r_cnt == LAST_IDX);

    // strict less-than keeps the newest among equal wildcard counts
    assign better   = i_head.hit && (i_head.wild < r_best);
    assign cur_best = better ? i_head.wild : r_best;
    assign cur_tag  = better ? i_head.tag : r_tag;
    assign cur_idx  = better ? r_cnt : r_idx;
    assign found    = (cur_best != NO_MATCH_WILD);

    always_comb begin
        ctl.insert = accept && (i_mode == MODE_INSERT) && !i_full;
        ctl.load   = accept && ((i_mode == MODE_LOOKUP) || (i_mode == MODE_REMOVE));
        ctl.shift  = (r_state == SCAN);
        ctl.remove = last && (r_mode == MODE_REMOVE) && found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_best  <= NO_MATCH_WILD;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                IDLE: begin
                    if (accept) begin
                        r_mode <= i_mode;
                        r_cnt  <= '0;
                        r_best <= NO_MATCH_WILD;
                        r_tag  <= 8'd0;
                        r_idx  <= '0;
                        if (ctl.load) begin
                            r_state <= SCAN;
                        end else begin
                            r_done             <= 1'b1;
                            r_rsp.found_tag      <= 8'd0;
                            r_rsp.wildcard_count <= 2'd0;
                            if (i_mode == MODE_INSERT) begin
                                r_rsp.status <= i_full ? ST_FULL : ST_OK;
                            end else begin
                                r_rsp.status <= ST_MISS;
                            end
                        end
                    end
                end
                SCAN: begin
                    r_best <= cur_best;
                    r_tag  <= cur_tag;
                    r_idx  <= cur_idx;
                    r_cnt  <= r_cnt + IDXW'(1);
                    if (last) begin
                        r_state <= IDLE;
                        r_done  <= 1'b1;
                        if (r_mode == MODE_LOOKUP) begin
                            r_rsp.status         <= found ? ST_OK : ST_MISS;
                            r_rsp.found_tag      <= found ? cur_tag : 8'd0;
                            r_rsp.wildcard_count <= found ? cur_best : 2'd0;
                        end else begin
                            r_rsp.status         <= found ? ST_OK : ST_NOTAG;
                            r_rsp.found_tag      <= 8'd0;
                            r_rsp.wildcard_count <= 2'd0;
                        end
                    end
                end
                default: begin
                    r_state <= IDLE;
                end
            endcase
        end
    end

    assign o_ctl     = ctl;
    assign o_hit_idx = cur_idx;
    assign o_busy    = (r_state != IDLE);
    assign o_done    = r_done;
    assign o_rsp     = r_rsp;

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last |=> (r_state == IDLE) && r_done)
        else $error("scan did not end with a result");

    a_remove_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.remove |-> (r_state == SCAN) && (r_mode == MODE_REMOVE) && !ctl.insert)
        else $error("table compaction outside a remove scan");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.insert |-> !i_full && !ctl.load)
        else $error("insert into a full table");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_rsp.status != ST_OK)) |->
            (r_rsp.found_tag == 8'd0) && (r_rsp.wildcard_count == 2'd0))
        else $error("non-hit result carries a tag");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SCAN) && (r_best != NO_MATCH_WILD) && (r_mode == MODE_REMOVE)
            |-> (r_best == 2'd0))
        else $error("remove scan recorded a wildcard count");

endmodule

### rtl/core/socket_endpoint_wildcard_lookup_top.sv
// Endpoint table with wildcard best-match lookup.
// Request channel: i_req is taken at a rising edge with i_start high and
// o_busy low. Modes: insert at the head of the search order, lookup, and
// remove by tag. Result channel: o_rsp is valid for the single cycle that
// o_done is high; there is no backpressure, the receiver must take it.
// The table is a row of TABLE_DEPTH cells, one entry each. Insert shifts
// every cell one place older unless the table is full; the result strobes
// in the cycle after the request, and a new request may come in that same
// cycle. Lookup and remove compare in every cell at the request edge, then
// the per-cell results shift toward cell 0 while the controller keeps the
// newest entry with the fewest wildcards. A remove closes the gap in the
// table at the edge that raises the strobe. o_busy is high for the scan,
// so no new request is taken until the scan is through. Other mode codes
// answer "no match" in the cycle after the request. Reset empties the
// table; no clearing pass is needed.
module socket_endpoint_wildcard_lookup_top #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sewl_pkg::t_req  i_req,
    output logic            o_busy,
    output logic            o_done,
    output sewl_pkg::t_rsp  o_rsp
);
    import sewl_pkg::*;

    localparam int unsigned IDXW = $clog2(TABLE_DEPTH);

    t_cell_ctl       ctl;
    logic [IDXW-1:0] hit_idx;
    t_entry          new_entry;
    t_entry          entry_q [TABLE_DEPTH];
    t_scan           scan_q  [TABLE_DEPTH];

    always_comb begin
        new_entry.valid        = 1'b1;
        new_entry.local_addr   = i_req.local_addr;
        new_entry.local_port   = i_req.local_port;
        new_entry.foreign_addr = i_req.foreign_addr;
        new_entry.foreign_port = i_req.foreign_port;
        new_entry.tag          = i_req.entry_tag;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry newer;
        t_entry older;
        t_scan  older_scan;
        if (g == 0) begin : g_head
            assign newer = new_entry;
        end else begin : g_mid
            assign newer = entry_q[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign older      = '0;
            assign older_scan = '0;
        end else begin : g_body
            assign older      = entry_q[g+1];
            assign older_scan = scan_q[g+1];
        end
        sewl_cell #(
            .DEPTH (TABLE_DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_hit_idx    (hit_idx),
            .i_req        (i_req),
            .i_newer      (newer),
            .i_older      (older),
            .i_older_scan (older_scan),
            .o_entry      (entry_q[g]),
            .o_scan       (scan_q[g])
        );
    end

    sewl_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_mode    (i_req.mode),
        .i_head    (scan_q[0]),
        .i_full    (entry_q[TABLE_DEPTH-1].valid),
        .o_ctl     (ctl),
        .o_hit_idx (hit_idx),
        .o_busy    (o_busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp)
    );

endmodule
